FILE: rtl/piecewise_linear_calibration_converter_assert.svh
// Assertion macros shared by the checker files.
`ifndef PIECEWISE_LINEAR_CALIBRATION_CONVERTER_ASSERT_SVH
`define PIECEWISE_LINEAR_CALIBRATION_CONVERTER_ASSERT_SVH

// Clocked assertion that is disabled while reset is held.
`define PLCC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Clocked assertion that also holds during reset.
`define PLCC_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

FILE: rtl/plcc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package plcc_pkg;

  localparam int MAX_POINTS = 64;
  localparam int IDX_W      = $clog2(MAX_POINTS);
  localparam int CNT_W      = $clog2(MAX_POINTS + 1);

  typedef enum logic [1:0] {
    OP_WRITE = 2'd0,
    OP_V2T   = 2'd1,
    OP_T2V   = 2'd2,
    OP_READ  = 2'd3
  } opcode_t;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_BADIDX = 2'd1,
    ST_ZEROW  = 2'd2,
    ST_NOSEG  = 2'd3
  } status_t;

  // Item travelling down the cell chain.
  typedef struct packed {
    logic               vld;
    opcode_t            op;
    logic [IDX_W-1:0]   idx;
    logic               bad;
    logic signed [31:0] wv;
    logic signed [31:0] wt;
    logic signed [31:0] q;
    logic               below0;
    logic signed [31:0] pk;
    logic signed [31:0] pv;
    logic               sel_vld;
    logic signed [31:0] k1;
    logic signed [31:0] v1;
    logic signed [31:0] k2;
    logic signed [31:0] v2;
    logic signed [31:0] rv;
    logic signed [31:0] rt;
  } pkt_t;

  typedef struct packed {
    logic first;
    logic one;
    logic mid;
    logic last;
  } role_t;

  typedef struct packed {
    logic signed [31:0] conv;
    logic signed [31:0] sv;
    logic signed [31:0] st;
    status_t            status;
  } res_t;

endpackage
`default_nettype wire

FILE: rtl/plcc_cell.sv
`timescale 1ns / 1ps
`default_nettype none
module plcc_cell (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic [plcc_pkg::IDX_W-1:0] my_idx,
  input  wire plcc_pkg::role_t       role,
  input  wire plcc_pkg::pkt_t        pkt_i,
  output plcc_pkg::pkt_t             pkt_o
);
  import plcc_pkg::*;

  logic signed [31:0] v_r;
  logic signed [31:0] t_r;
  pkt_t               pkt_r;
  pkt_t               pkt_nxt;
  logic signed [31:0] key;
  logic signed [31:0] val;
  logic               hit;
  logic               take;

  assign hit = (pkt_i.idx == my_idx);
  assign key = (pkt_i.op == OP_T2V) ? t_r : v_r;
  assign val = (pkt_i.op == OP_T2V) ? v_r : t_r;

  // Segment choice: below the first point wins, then the first interior
  // point above the key, then the last segment.
  assign take = (role.one && pkt_i.below0) ||
                (role.mid && !pkt_i.sel_vld && (pkt_i.q < key)) ||
                (role.last && !pkt_i.below0 && ((pkt_i.q >= key) || !pkt_i.sel_vld));

  always_comb begin
    pkt_nxt    = pkt_i;
    pkt_nxt.pk = key;
    pkt_nxt.pv = val;
    if (role.first) begin
      pkt_nxt.below0 = (pkt_i.q <= key);
    end
    if (take) begin
      pkt_nxt.sel_vld = 1'b1;
      pkt_nxt.k1      = pkt_i.pk;
      pkt_nxt.v1      = pkt_i.pv;
      pkt_nxt.k2      = key;
      pkt_nxt.v2      = val;
    end
    if (pkt_i.op == OP_READ && hit) begin
      pkt_nxt.rv = v_r;
      pkt_nxt.rt = t_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pkt_r.vld <= 1'b0;
    end else begin
      pkt_r.vld <= pkt_nxt.vld;
    end
    pkt_r.op      <= pkt_nxt.op;
    pkt_r.idx     <= pkt_nxt.idx;
    pkt_r.bad     <= pkt_nxt.bad;
    pkt_r.wv      <= pkt_nxt.wv;
    pkt_r.wt      <= pkt_nxt.wt;
    pkt_r.q       <= pkt_nxt.q;
    pkt_r.below0  <= pkt_nxt.below0;
    pkt_r.pk      <= pkt_nxt.pk;
    pkt_r.pv      <= pkt_nxt.pv;
    pkt_r.sel_vld <= pkt_nxt.sel_vld;
    pkt_r.k1      <= pkt_nxt.k1;
    pkt_r.v1      <= pkt_nxt.v1;
    pkt_r.k2      <= pkt_nxt.k2;
    pkt_r.v2      <= pkt_nxt.v2;
    pkt_r.rv      <= pkt_nxt.rv;
    pkt_r.rt      <= pkt_nxt.rt;
  end

  always_ff @(posedge clk) begin
    if (pkt_i.vld && pkt_i.op == OP_WRITE && !pkt_i.bad && hit) begin
      v_r <= pkt_i.wv;
      t_r <= pkt_i.wt;
    end
  end

  assign pkt_o = pkt_r;
endmodule
`default_nettype wire

FILE: rtl/plcc_interp.sv
`timescale 1ns / 1ps
`default_nettype none
module plcc_interp (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire plcc_pkg::pkt_t pkt_i,
  input  wire logic           take_i,
  output logic                done_o,
  output plcc_pkg::res_t      res_o
);
  import plcc_pkg::*;

  localparam int MUL_STEPS = 33;
  localparam int DIV_STEPS = 66;

  typedef enum logic [2:0] {S_IDLE, S_MUL, S_DIV, S_FIN, S_DONE} state_t;

  state_t             state_r;
  logic [6:0]         cnt_r;
  logic [65:0]        a_r;
  logic [32:0]        b_r;
  logic [65:0]        prod_r;
  logic [32:0]        d_r;
  logic [32:0]        rem_r;
  logic               neg_r;
  logic signed [31:0] y1_r;
  res_t               res_r;

  logic signed [32:0] dx;
  logic signed [32:0] dy;
  logic signed [32:0] dq;
  logic [33:0]        trial;
  logic               ge;
  logic               sat;
  logic signed [36:0] y1e;
  logic signed [36:0] qe;
  logic signed [36:0] r;
  logic               over;
  logic               under;

  assign dx = {pkt_i.k2[31], pkt_i.k2} - {pkt_i.k1[31], pkt_i.k1};
  assign dy = {pkt_i.v2[31], pkt_i.v2} - {pkt_i.v1[31], pkt_i.v1};
  assign dq = {pkt_i.q[31], pkt_i.q} - {pkt_i.k1[31], pkt_i.k1};

  assign trial = {rem_r, prod_r[65]};
  assign ge    = (trial >= {1'b0, d_r});

  // Quotient limit of 2^34 mirrors the saturation window of the result.
  assign sat   = (|prod_r[65:35]) || (prod_r[34] && (|prod_r[33:0]));
  assign y1e   = 37'(y1_r);
  assign qe    = $signed({2'b00, prod_r[34:0]});
  assign r     = neg_r ? (y1e - qe) : (y1e + qe);
  assign over  = !r[36] && (|r[35:31]);
  assign under = r[36] && !(&r[35:31]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      unique case (state_r)
        S_IDLE: begin
          if (pkt_i.vld) begin
            if (pkt_i.op == OP_WRITE || pkt_i.op == OP_READ) begin
              res_r.conv <= '0;
              if (pkt_i.bad) begin
                res_r.sv     <= '0;
                res_r.st     <= '0;
                res_r.status <= ST_BADIDX;
              end else if (pkt_i.op == OP_READ) begin
                res_r.sv     <= pkt_i.rv;
                res_r.st     <= pkt_i.rt;
                res_r.status <= ST_OK;
              end else begin
                res_r.sv     <= '0;
                res_r.st     <= '0;
                res_r.status <= ST_OK;
              end
              state_r <= S_DONE;
            end else if (dx == '0) begin
              res_r.conv   <= '0;
              res_r.sv     <= '0;
              res_r.st     <= '0;
              res_r.status <= ST_ZEROW;
              state_r      <= S_DONE;
            end else begin
              res_r.sv     <= '0;
              res_r.st     <= '0;
              res_r.status <= ST_OK;
              a_r     <= 66'(dy[32] ? 33'(-dy) : 33'(dy));
              b_r     <= dq[32] ? 33'(-dq) : 33'(dq);
              d_r     <= dx[32] ? 33'(-dx) : 33'(dx);
              neg_r   <= dy[32] ^ dq[32] ^ dx[32];
              y1_r    <= pkt_i.v1;
              prod_r  <= '0;
              cnt_r   <= '0;
              state_r <= S_MUL;
            end
          end
        end
        S_MUL: begin
          if (b_r[0]) begin
            prod_r <= prod_r + a_r;
          end
          a_r   <= {a_r[64:0], 1'b0};
          b_r   <= {1'b0, b_r[32:1]};
          if (cnt_r == 7'(MUL_STEPS - 1)) begin
            cnt_r   <= '0;
            rem_r   <= '0;
            state_r <= S_DIV;
          end else begin
            cnt_r <= cnt_r + 7'd1;
          end
        end
        S_DIV: begin
          // Restoring division, one quotient bit per cycle into the dividend.
          rem_r  <= ge ? 33'(trial - {1'b0, d_r}) : trial[32:0];
          prod_r <= {prod_r[64:0], ge};
          cnt_r  <= cnt_r + 7'd1;
          if (cnt_r == 7'(DIV_STEPS - 1)) begin
            state_r <= S_FIN;
          end
        end
        S_FIN: begin
          if (sat) begin
            res_r.conv <= neg_r ? 32'sh8000_0000 : 32'sh7fff_ffff;
          end else if (over) begin
            res_r.conv <= 32'sh7fff_ffff;
          end else if (under) begin
            res_r.conv <= 32'sh8000_0000;
          end else begin
            res_r.conv <= r[31:0];
          end
          state_r <= S_DONE;
        end
        S_DONE: begin
          if (take_i) begin
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign done_o = (state_r == S_DONE);
  assign res_o  = res_r;
endmodule
`default_nettype wire

FILE: rtl/piecewise_linear_calibration_converter.sv
`timescale 1ns / 1ps
`default_nettype none
// Piecewise-linear calibration converter.
// Input channel (in_valid / in_stall): one beat carries an opcode, an entry
// index, a point to write and a query value. The block takes one item at a
// time and holds in_stall high until the result of that item has been loaded
// into the output register.
// Every item travels a chain of 64 cells, one cell per cycle; each cell holds
// one calibration point and picks the segment, writes or reads its point.
// Table writes and reads skip the arithmetic: their result is loaded from the
// end of the chain straight into the result register.
// Conversions then run a shift-add multiplier and a restoring divider before
// the result is saturated to 32 bits and loaded.
// Output channel (out_valid / out_stall): the result waits in its register
// while the receiver stalls; a new item may be accepted meanwhile.
// Configuration (cfg_valid / cfg_ready): cfg_ready is always high; the
// written value sets the number of points in use, clamped to 2..64.
// Reset sets the point count to 64 and empties the chain; table contents are
// undefined until written.
module piecewise_linear_calibration_converter (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [1:0]  in_opcode,
  input  wire logic [5:0]  in_entry_index,
  input  wire logic signed [31:0] in_entry_volts,
  input  wire logic signed [31:0] in_entry_temp,
  input  wire logic signed [31:0] in_query_value,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic signed [31:0] out_converted,
  output logic signed [31:0] out_stored_volts,
  output logic signed [31:0] out_stored_temp,
  output logic [1:0]       out_status,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [6:0]  cfg_points_in_use
);
  import plcc_pkg::*;

  logic [CNT_W-1:0] cfg_r;
  logic [CNT_W-1:0] n_eff;
  logic             busy_r;
  pkt_t             in_pkt_r;
  pkt_t             chain [0:MAX_POINTS];
  logic             done;
  res_t             res;
  logic             take;
  logic             accept;
  logic             out_valid_r;
  res_t             out_r;

  assign cfg_ready = 1'b1;
  assign n_eff = (cfg_r < CNT_W'(2)) ? CNT_W'(2) :
                 (cfg_r > CNT_W'(MAX_POINTS)) ? CNT_W'(MAX_POINTS) : cfg_r;

  assign in_stall = busy_r;
  assign accept   = in_valid && !busy_r;
  assign take     = done && !(out_valid_r && out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r        <= CNT_W'(MAX_POINTS);
      busy_r       <= 1'b0;
      in_pkt_r.vld <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      if (cfg_valid) begin
        cfg_r <= CNT_W'(cfg_points_in_use);
      end
      in_pkt_r.vld <= accept;
      if (accept) begin
        busy_r <= 1'b1;
      end else if (take) begin
        busy_r <= 1'b0;
      end
      if (take) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
    if (accept) begin
      in_pkt_r.op      <= opcode_t'(in_opcode);
      in_pkt_r.idx     <= in_entry_index;
      in_pkt_r.bad     <= (CNT_W'(in_entry_index) >= n_eff);
      in_pkt_r.wv      <= in_entry_volts;
      in_pkt_r.wt      <= in_entry_temp;
      in_pkt_r.q       <= in_query_value;
      in_pkt_r.below0  <= 1'b0;
      in_pkt_r.pk      <= '0;
      in_pkt_r.pv      <= '0;
      in_pkt_r.sel_vld <= 1'b0;
      in_pkt_r.k1      <= '0;
      in_pkt_r.v1      <= '0;
      in_pkt_r.k2      <= '0;
      in_pkt_r.v2      <= '0;
      in_pkt_r.rv      <= '0;
      in_pkt_r.rt      <= '0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      out_r <= res;
    end
  end

  assign chain[0] = in_pkt_r;

  for (genvar i = 0; i < MAX_POINTS; i++) begin : g_cell
    role_t role;
    assign role.first = (i == 0);
    assign role.one   = (i == 1);
    assign role.mid   = (i >= 1) && (CNT_W'(i) <= n_eff - CNT_W'(2));
    assign role.last  = (CNT_W'(i) == n_eff - CNT_W'(1));

    plcc_cell u_cell (
      .clk    (clk),
      .rst_n  (rst_n),
      .my_idx (IDX_W'(i)),
      .role   (role),
      .pkt_i  (chain[i]),
      .pkt_o  (chain[i+1])
    );
  end

  plcc_interp u_interp (
    .clk    (clk),
    .rst_n  (rst_n),
    .pkt_i  (chain[MAX_POINTS]),
    .take_i (take),
    .done_o (done),
    .res_o  (res)
  );

  assign out_valid        = out_valid_r;
  assign out_converted    = out_r.conv;
  assign out_stored_volts = out_r.sv;
  assign out_stored_temp  = out_r.st;
  assign out_status       = out_r.status;
endmodule
`default_nettype wire

FILE: rtl/plcc_checker.sv
`timescale 1ns / 1ps
`default_nettype none
`include "piecewise_linear_calibration_converter_assert.svh"
module plcc_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_valid,
  input wire logic        in_stall,
  input wire logic        out_valid,
  input wire logic        out_stall,
  input wire logic [31:0] out_converted,
  input wire logic [31:0] out_stored_volts,
  input wire logic [31:0] out_stored_temp,
  input wire logic [1:0]  out_status
);
  import plcc_pkg::*;

  // A stalled result beat stays and keeps its conversion and status.
  `PLCC_ASSERT(a_out_hold, out_valid && out_stall |=> out_valid, "result beat dropped")
  `PLCC_ASSERT(a_out_stable, out_valid && out_stall |=> $stable(out_converted) && $stable(out_status), "stalled result changed")
  // Errors always come with a zero conversion and no read data.
  `PLCC_ASSERT(a_err_zero, out_valid && out_status != ST_OK |-> out_converted == '0 && out_stored_volts == '0 && out_stored_temp == '0, "error result not zero")
  // One item at a time: an accepted beat closes the input.
  `PLCC_ASSERT(a_one_item, in_valid && !in_stall |=> in_stall, "second item taken while busy")
  `PLCC_ASSERT_ALWAYS(a_rst_idle, !rst_n |=> !out_valid && !in_stall, "reset left block active")
endmodule

bind piecewise_linear_calibration_converter plcc_checker u_plcc_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_valid         (in_valid),
  .in_stall         (in_stall),
  .out_valid        (out_valid),
  .out_stall        (out_stall),
  .out_converted    (out_converted),
  .out_stored_volts (out_stored_volts),
  .out_stored_temp  (out_stored_temp),
  .out_status       (out_status)
);
`default_nettype wire

FILE: bench/tb_piecewise_linear_calibration_converter.sv
`timescale 1ns / 1ps
module tb_piecewise_linear_calibration_converter;
  import plcc_pkg::*;

  typedef struct {
    opcode_t            op;
    logic [5:0]         idx;
    logic signed [31:0] ev;
    logic signed [31:0] et;
    logic signed [31:0] q;
  } cal_cmd_t;

  localparam logic signed [31:0] VMIN = 32'sh8000_0000;
  localparam logic signed [31:0] VMAX = 32'sh7fff_ffff;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [1:0] in_opcode = '0;
  logic [5:0] in_entry_index = '0;
  logic signed [31:0] in_entry_volts = '0;
  logic signed [31:0] in_entry_temp = '0;
  logic signed [31:0] in_query_value = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [31:0] out_converted;
  logic signed [31:0] out_stored_volts;
  logic signed [31:0] out_stored_temp;
  logic [1:0] out_status;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [6:0] cfg_points_in_use = '0;

  piecewise_linear_calibration_converter u_top (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall),
    .in_opcode(in_opcode), .in_entry_index(in_entry_index),
    .in_entry_volts(in_entry_volts), .in_entry_temp(in_entry_temp),
    .in_query_value(in_query_value),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_converted(out_converted), .out_stored_volts(out_stored_volts),
    .out_stored_temp(out_stored_temp), .out_status(out_status),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_points_in_use(cfg_points_in_use)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  cal_cmd_t cmd_q[$];
  res_t result_q[$];
  int errors = 0;
  int unsigned cyc = 0;
  int hold_cnt = 0;

  // Predictor state: calibration table and point count.
  logic signed [31:0] cal_volts[64];
  logic signed [31:0] cal_temps[64];
  logic [6:0] pts_reg = 7'd64;

  // Generator shadow of the table, used to aim queries near the points.
  logic signed [31:0] gen_volts[64];
  logic signed [31:0] gen_temps[64];
  int gen_n = 64;

  function automatic int clamp_points(input logic [6:0] r);
    if (r < 2) return 2;
    if (r > 64) return 64;
    return int'(r);
  endfunction

  function automatic void interpolate(input bit volt_key, input logic signed [31:0] q,
                                      output logic signed [31:0] r, output status_t st);
    int n;
    int j;
    longint x1, x2, y1, y2, dx, dy, dq, rr;
    bit neg;
    bit [127:0] prod, quot;
    logic signed [31:0] kx[64];
    logic signed [31:0] vy[64];
    n = clamp_points(pts_reg);
    foreach (kx[i]) begin
      kx[i] = volt_key ? cal_volts[i] : cal_temps[i];
      vy[i] = volt_key ? cal_temps[i] : cal_volts[i];
    end
    j = 1;
    if (q <= kx[0]) j = 1;
    else if (q >= kx[n-1]) j = n - 1;
    else begin
      for (j = 1; j < n - 1; j++)
        if (q < kx[j]) break;
    end
    x1 = kx[j-1]; x2 = kx[j]; y1 = vy[j-1]; y2 = vy[j];
    dx = x2 - x1;
    st = ST_OK;
    if (dx == 0) begin
      r = '0;
      st = ST_ZEROW;
      return;
    end
    dy = y2 - y1;
    dq = longint'(q) - x1;
    neg = ((dy < 0) != (dq < 0)) != (dx < 0);
    prod = {64'd0, 64'(dy < 0 ? -dy : dy)} * {64'd0, 64'(dq < 0 ? -dq : dq)};
    quot = prod / {64'd0, 64'(dx < 0 ? -dx : dx)};
    if (quot > 128'd17179869184) begin
      r = neg ? VMIN : VMAX;
      if (dy == 0 || dq == 0) r = y1[31:0];
      return;
    end
    rr = neg ? y1 - longint'(quot[63:0]) : y1 + longint'(quot[63:0]);
    if (rr > 64'sd2147483647) rr = 64'sd2147483647;
    if (rr < -64'sd2147483648) rr = -64'sd2147483648;
    r = rr[31:0];
  endfunction

  function automatic res_t calibrate(input cal_cmd_t c);
    res_t res;
    int n;
    n = clamp_points(pts_reg);
    res = '{conv: '0, sv: '0, st: '0, status: ST_OK};
    case (c.op)
      OP_WRITE, OP_READ: begin
        if (int'(c.idx) >= n) res.status = ST_BADIDX;
        else if (c.op == OP_WRITE) begin
          cal_volts[c.idx] = c.ev;
          cal_temps[c.idx] = c.et;
        end else begin
          res.sv = cal_volts[c.idx];
          res.st = cal_temps[c.idx];
        end
      end
      OP_V2T: interpolate(1'b1, c.q, res.conv, res.status);
      default: interpolate(1'b0, c.q, res.conv, res.status);
    endcase
    if (res.status != ST_OK) res.conv = '0;
    return res;
  endfunction

  function automatic bit quiet_window();
    return cyc > 40000 && cyc < 100000;
  endfunction

  // Driver: offers the next pending command once the current beat is taken.
  always @(posedge clk) begin
    cyc <= cyc + 1;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall)
        result_q.push_back(calibrate('{op: opcode_t'(in_opcode), idx: in_entry_index,
          ev: in_entry_volts, et: in_entry_temp, q: in_query_value}));
      if (!in_valid || !in_stall) begin
        if (cmd_q.size() > 0 && (quiet_window() || $urandom_range(99) >= 6)) begin
          in_valid <= 1'b1;
          in_opcode <= cmd_q[0].op;
          in_entry_index <= cmd_q[0].idx;
          in_entry_volts <= cmd_q[0].ev;
          in_entry_temp <= cmd_q[0].et;
          in_query_value <= cmd_q[0].q;
          void'(cmd_q.pop_front());
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Long receiver hold-off, so that a finished item backs up the input side.
  always @(posedge clk) begin
    if (cyc == 3000 || cyc == 200000) hold_cnt <= 600;
    else if (hold_cnt > 0) hold_cnt <= hold_cnt - 1;
  end

  always @(posedge clk) begin
    res_t exp_r;
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      out_stall <= (hold_cnt > 1) || (!quiet_window() && $urandom_range(99) < 6);
      if (out_valid && !out_stall) begin
        if (result_q.size() == 0) begin
          $error("result beat with no command outstanding");
          errors++;
        end else begin
          exp_r = result_q.pop_front();
          if (out_converted !== exp_r.conv) begin
            $error("converted: expected %0d, got %0d", exp_r.conv, out_converted);
            errors++;
          end
          if (out_stored_volts !== exp_r.sv) begin
            $error("stored_volts: expected %0d, got %0d", exp_r.sv, out_stored_volts);
            errors++;
          end
          if (out_stored_temp !== exp_r.st) begin
            $error("stored_temp: expected %0d, got %0d", exp_r.st, out_stored_temp);
            errors++;
          end
          if (out_status !== exp_r.status) begin
            $error("status: expected %0d, got %0d", exp_r.status, out_status);
            errors++;
          end
        end
      end
    end
  end

  function automatic logic signed [31:0] any_value();
    case ($urandom_range(7))
      0: return VMIN;
      1: return VMAX;
      2: return '0;
      3, 4: return $urandom;
      default: return $signed($urandom_range(200000)) - 100000;
    endcase
  endfunction

  task automatic push_cmd(input opcode_t op, input int idx, input logic signed [31:0] ev,
                          input logic signed [31:0] et, input logic signed [31:0] q);
    cmd_q.push_back('{op: op, idx: 6'(idx), ev: ev, et: et, q: q});
    if (op == OP_WRITE && idx < gen_n) begin
      gen_volts[idx] = ev;
      gen_temps[idx] = et;
    end
  endtask

  // Rewrites all points in use with a rising voltage column; a zero step now
  // and then leaves a zero-width segment.
  task automatic fill_table();
    logic signed [31:0] v, t;
    v = $signed($urandom_range(400000)) - 200000;
    t = $signed($urandom_range(40000)) - 20000;
    for (int i = 0; i < gen_n; i++) begin
      push_cmd(OP_WRITE, i, v, t, $urandom);
      v = v + (($urandom_range(19) == 0) ? 0 : $signed($urandom_range(1, 20000)));
      t = t + $signed($urandom_range(6000)) - 1000;
    end
  endtask

  task automatic random_cmd();
    opcode_t op;
    int idx, k;
    logic signed [31:0] q;
    op = opcode_t'($urandom_range(3));
    idx = ($urandom_range(9) == 0) ? $urandom_range(63) : $urandom_range(gen_n - 1);
    k = $urandom_range(gen_n - 1);
    case ($urandom_range(5))
      0: q = any_value();
      1: q = (op == OP_V2T) ? gen_volts[k] : gen_temps[k];
      default: q = ((op == OP_V2T) ? gen_volts[k] : gen_temps[k])
                   + $signed($urandom_range(40000)) - 20000;
    endcase
    push_cmd(op, idx, any_value(), any_value(), q);
  endtask

  task automatic wait_idle();
    do @(posedge clk); while (cmd_q.size() != 0 || in_valid || result_q.size() != 0);
    repeat (200) @(posedge clk);
  endtask

  task automatic write_points(input logic [6:0] value);
    cfg_valid <= 1'b1;
    cfg_points_in_use <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    pts_reg = value;
    gen_n = clamp_points(value);
  endtask

  initial begin
    logic [6:0] setting;
    logic [6:0] settings[$] = '{7'd64, 7'd2, 7'd0, 7'd127, 7'd1, 7'd100, 7'd33, 7'd64};
    foreach (cal_volts[i]) begin
      cal_volts[i] = '0;
      cal_temps[i] = '0;
    end
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    // After reset all 64 points are in use; write every one before any read.
    fill_table();
    repeat (60) random_cmd();
    wait_idle();

    write_points(7'd4);
    push_cmd(OP_WRITE, 0, VMIN, VMIN, '0);
    push_cmd(OP_WRITE, 1, '0, VMAX, '0);
    push_cmd(OP_WRITE, 2, '0, 32'sd5, '0);
    push_cmd(OP_WRITE, 3, VMAX, VMIN, '0);
    push_cmd(OP_WRITE, 63, 32'sd1, 32'sd1, '0);
    push_cmd(OP_READ, 3, '0, '0, '0);
    push_cmd(OP_READ, 63, '0, '0, '0);
    push_cmd(OP_READ, 0, '0, '0, '0);
    foreach (settings[i]) begin
      push_cmd(OP_V2T, 0, '0, '0, (i % 2) ? VMAX : VMIN);
      push_cmd(OP_T2V, 0, '0, '0, (i % 2) ? VMIN : VMAX);
    end
    push_cmd(OP_V2T, 0, '0, '0, '0);
    push_cmd(OP_V2T, 0, '0, '0, -32'sd1);
    push_cmd(OP_T2V, 0, '0, '0, 32'sd1);
    wait_idle();

    for (int ph = 0; ph < 14; ph++) begin
      setting = (ph < settings.size()) ? settings[ph] : 7'($urandom_range(127));
      write_points(setting);
      fill_table();
      repeat (70) random_cmd();
      wait_idle();
    end

    if (errors == 0)
      $display("end of test: clean");
    else
      $display("end of test: mismatches");
    $finish;
  end

  initial begin
    #30ms;
    $display("end of test: mismatches");
    $finish;
  end

endmodule
